// ===== design/rgb_conv2d_zero_boundary_defines.svh =====
// Assertion helpers shared by the checker
`ifndef RGB_CONV2D_ZERO_BOUNDARY_DEFINES_SVH
`define RGB_CONV2D_ZERO_BOUNDARY_DEFINES_SVH

// same-cycle implication, off during reset
`define RCZ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcz check failed");

// next-cycle implication, off during reset
`define RCZ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcz check failed");

`endif

// ===== design/rcz_pkg.sv =====
package rcz_pkg;

    localparam int CFG_DIM_W  = 7;
    localparam int KSIZE_W    = 3;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int TAP_W      = 3;
    localparam int CH_W       = 2;
    localparam int WEIGHT_W   = 16;
    localparam int SAMPLE_W   = 8;
    localparam int PIXEL_W    = 3 * SAMPLE_W;
    localparam int PROD_W     = SAMPLE_W + 1 + WEIGHT_W;
    localparam int SUM_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int NUM_CH     = 3;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_MAX_KERNEL = 7;

    localparam logic [CFG_DIM_W-1:0] RST_IMAGE_WIDTH  = 7'd64;
    localparam logic [CFG_DIM_W-1:0] RST_IMAGE_HEIGHT = 7'd64;
    localparam logic [KSIZE_W-1:0]   RST_KERNEL_SIZE  = 3'd3;

    localparam logic [1:0] REQ_WRITE_TAP   = 2'd0;
    localparam logic [1:0] REQ_WRITE_PIXEL = 2'd1;
    localparam logic [1:0] REQ_COMPUTE     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE  = 2'd2;

    localparam logic [CH_W-1:0] CH_RED   = 2'd0;
    localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic [ROW_W-1:0]           pix_row;
        logic [COL_W-1:0]           pix_col;
        logic [TAP_W-1:0]           tap_row;
        logic [TAP_W-1:0]           tap_col;
        logic [CH_W-1:0]            channel;
        logic signed [WEIGHT_W-1:0] tap_weight;
        logic [SAMPLE_W-1:0]        red;
        logic [SAMPLE_W-1:0]        green;
        logic [SAMPLE_W-1:0]        blue;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_W-1:0] conv_sum;
        logic [ROW_W-1:0]        out_row;
        logic [COL_W-1:0]        out_col;
        logic                    range_error;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic pos_bad;
        logic last_tap;
        logic pipe_busy;
        logic out_free;
    } t_dp_status;

endpackage

// ===== design/rcz_in_if.sv =====
interface rcz_in_if import rcz_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/rcz_out_if.sv =====
interface rcz_out_if import rcz_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/rcz_ctrl.sv =====
module rcz_ctrl import rcz_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_req_type,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   compute_accept;

    assign compute_accept = (r_state == ST_IDLE) && i_in_valid && (i_req_type == REQ_COMPUTE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (compute_accept) begin
                    n_state = i_status.pos_bad ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_status.last_tap) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.start    = 1'b0;
        o_cmd.step     = 1'b0;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = compute_accept;
            end
            ST_RUN: begin
                o_cmd.step = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_DONE: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== design/rcz_datapath.sv =====
module rcz_datapath import rcz_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_accept,
    input  t_in_item              i_in_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output t_out_item             o_out_data
);

    localparam int F_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int FAW     = (F_DEPTH > 1) ? $clog2(F_DEPTH) : 1;
    localparam int W_DEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int WAW     = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;

    // configuration
    logic [CFG_DIM_W-1:0] r_image_width;
    logic [CFG_DIM_W-1:0] r_image_height;
    logic [KSIZE_W-1:0]   r_kernel_size;
    logic [CFG_DIM_W-1:0] w_eff;
    logic [CFG_DIM_W-1:0] h_eff;
    logic [KSIZE_W-1:0]   k_eff;
    logic [KSIZE_W-1:0]   k_last;
    logic [KSIZE_W-1:0]   center;

    // request and tap walk
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic               r_bad;
    logic [KSIZE_W-1:0] r_kr;
    logic [KSIZE_W-1:0] r_kc;
    logic signed [8:0]  tap_ii;
    logic signed [8:0]  tap_jj;
    logic               tap_in_img;
    logic [FAW-1:0]     frame_raddr;
    logic [WAW-1:0]     wt_raddr;
    logic [KSIZE_W-1:0] flip_r;
    logic [KSIZE_W-1:0] flip_c;

    // writes
    logic           frame_we;
    logic [FAW-1:0] frame_waddr;
    logic           tap_we;
    logic [WAW-1:0] wt_waddr;

    // pipeline
    logic                       r_rd_v;
    logic                       r_rd_in;
    logic [PIXEL_W-1:0]         r_pix;
    logic signed [WEIGHT_W-1:0] r_wt [NUM_CH];
    logic                       r_mul_v;
    logic signed [PROD_W-1:0]   r_prod [NUM_CH];
    logic signed [SUM_W-1:0]    r_acc;
    logic signed [SUM_W-1:0]    tap_sum;

    logic      r_out_valid;
    t_out_item r_out;

    logic [CFG_DIM_W-1:0] pos_row_ext;
    logic [CFG_DIM_W-1:0] pos_col_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
            r_kernel_size  <= RST_KERNEL_SIZE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_wdata;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_wdata;
                CFG_KERNEL_SIZE:  r_kernel_size  <= i_cfg_wdata[KSIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // clamp registers to their usable range
    always_comb begin
        if (r_image_width == '0) begin
            w_eff = CFG_DIM_W'(1);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            w_eff = CFG_DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = r_image_width;
        end
        if (r_image_height == '0) begin
            h_eff = CFG_DIM_W'(1);
        end else if (32'(r_image_height) > MAX_HEIGHT) begin
            h_eff = CFG_DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_image_height;
        end
        if (r_kernel_size == '0) begin
            k_eff = KSIZE_W'(1);
        end else if (32'(r_kernel_size) > MAX_KERNEL) begin
            k_eff = KSIZE_W'(MAX_KERNEL);
        end else begin
            k_eff = r_kernel_size;
        end
    end

    assign k_last = k_eff - KSIZE_W'(1);
    assign center = k_eff >> 1;

    assign pos_row_ext      = CFG_DIM_W'(i_in_data.pix_row);
    assign pos_col_ext      = CFG_DIM_W'(i_in_data.pix_col);
    assign o_status.pos_bad = (pos_row_ext >= h_eff) || (pos_col_ext >= w_eff);

    assign frame_we = i_accept && (i_in_data.req_type == REQ_WRITE_PIXEL)
                      && (32'(i_in_data.pix_row) < MAX_HEIGHT)
                      && (32'(i_in_data.pix_col) < MAX_WIDTH);
    assign frame_waddr = FAW'(i_in_data.pix_row * MAX_WIDTH + i_in_data.pix_col);

    assign tap_we = i_accept && (i_in_data.req_type == REQ_WRITE_TAP)
                    && (32'(i_in_data.tap_row) < MAX_KERNEL)
                    && (32'(i_in_data.tap_col) < MAX_KERNEL)
                    && (i_in_data.channel != 2'd3);
    assign wt_waddr = WAW'(i_in_data.tap_row * MAX_KERNEL + i_in_data.tap_col);

    // walk the kernel taps row by row
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_row <= i_in_data.pix_row;
            r_col <= i_in_data.pix_col;
            r_bad <= o_status.pos_bad;
            r_kr  <= '0;
            r_kc  <= '0;
        end else if (i_cmd.step) begin
            if (r_kc == k_last) begin
                r_kc <= '0;
                r_kr <= r_kr + KSIZE_W'(1);
            end else begin
                r_kc <= r_kc + KSIZE_W'(1);
            end
        end
    end

    assign o_status.last_tap = (r_kr == k_last) && (r_kc == k_last);

    assign tap_ii = $signed({3'b000, r_row}) + $signed({6'b000000, r_kr})
                    - $signed({6'b000000, center});
    assign tap_jj = $signed({3'b000, r_col}) + $signed({6'b000000, r_kc})
                    - $signed({6'b000000, center});
    assign tap_in_img = !tap_ii[8] && !tap_jj[8]
                        && (tap_ii < $signed({2'b00, h_eff}))
                        && (tap_jj < $signed({2'b00, w_eff}));

    assign frame_raddr = FAW'(tap_ii[7:0] * MAX_WIDTH + tap_jj[7:0]);
    assign flip_r      = k_last - r_kr;
    assign flip_c      = k_last - r_kc;
    assign wt_raddr    = WAW'(flip_r * MAX_KERNEL + flip_c);

    logic [PIXEL_W-1:0] frame_mem [F_DEPTH];

    always_ff @(posedge i_clk) begin
        if (frame_we) begin
            frame_mem[frame_waddr] <= {i_in_data.red, i_in_data.green, i_in_data.blue};
        end
        r_pix <= frame_mem[frame_raddr];
    end

    for (genvar g = 0; g < NUM_CH; g++) begin : g_wt
        logic signed [WEIGHT_W-1:0] wt_mem [W_DEPTH];

        always_ff @(posedge i_clk) begin
            if (tap_we && (i_in_data.channel == CH_W'(g))) begin
                wt_mem[wt_waddr] <= i_in_data.tap_weight;
            end
            r_wt[g] <= wt_mem[wt_raddr];
        end

        // red sits in the top byte
        always_ff @(posedge i_clk) begin
            if (r_rd_in) begin
                r_prod[g] <= $signed({1'b0, r_pix[PIXEL_W-1-g*SAMPLE_W -: SAMPLE_W]}) * r_wt[g];
            end else begin
                r_prod[g] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_in <= i_cmd.step && tap_in_img;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v  <= 1'b0;
            r_mul_v <= 1'b0;
        end else begin
            r_rd_v  <= i_cmd.step;
            r_mul_v <= r_rd_v;
        end
    end

    assign o_status.pipe_busy = r_rd_v || r_mul_v;

    assign tap_sum = SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]) + SUM_W'(r_prod[2]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_mul_v) begin
            r_acc <= r_acc + tap_sum;
        end
    end

    // result register: holds one transaction while the next request runs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.conv_sum    <= r_acc;
            r_out.out_row     <= r_row;
            r_out.out_col     <= r_col;
            r_out.range_error <= r_bad;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule

// ===== design/rgb_conv2d_zero_boundary.sv =====
// A write transaction is stored at the clock edge that accepts it. A compute
// walks the kernel one tap per cycle (K*K taps, K = kernel side) through the
// memory read, multiply and accumulate stages; an out-of-image compute skips
// the walk. Writes are taken one per cycle while no compute runs: a new request
// waits until the last result is loaded into the output register. Reset
// (synchronous, active low) restores config, state and output valid; stores stay.
module rgb_conv2d_zero_boundary import rcz_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    rcz_in_if.sink                i_in,
    rcz_out_if.source             o_out
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       in_ready;

    assign i_in.ready = in_ready;

    rcz_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_req_type (i_in.data.req_type),
        .i_status   (dp_status),
        .o_in_ready (in_ready),
        .o_cmd      (dp_cmd)
    );

    rcz_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (i_in.valid && in_ready),
        .i_in_data   (i_in.data),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_data  (o_out.data)
    );

endmodule

// ===== design/rcz_checker.sv =====
`include "rgb_conv2d_zero_boundary_defines.svh"

module rcz_checker import rcz_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_req_type,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input t_out_item  i_out_data
);

    // a stalled result transaction holds
    `RCZ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))

    // out-of-image results carry a zero sum
    `RCZ_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, i_out_valid && i_out_data.range_error, i_out_data.conv_sum == '0)

    // a compute transaction blocks the input for at least the next cycle
    `RCZ_ASSERT_NEXT(a_busy_after_compute, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_req_type == REQ_COMPUTE), !i_in_ready)

endmodule

bind rgb_conv2d_zero_boundary rcz_checker u_rcz_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_req_type (i_in.data.req_type),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_data    (o_out.data)
);
